// File: src/mobius_strip_vertex_generator_defines.svh
// Assertion macros for the mobius strip vertex generator.
// Expects clk and arst_n in the scope of each use.
`ifndef MOBIUS_STRIP_VERTEX_GENERATOR_DEFINES_SVH
`define MOBIUS_STRIP_VERTEX_GENERATOR_DEFINES_SVH

// same-cycle implication
`define MSVG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MSVG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/msvg_pkg.sv
// Shared constants, types and table builder for the mobius strip vertex generator.
// Depends on nothing; every module file imports it.
package msvg_pkg;

	localparam int PHASE_BITS  = 16;
	localparam int TABLE_DEPTH = 1024;   // power of two
	localparam int MAX_COLUMNS = 4096;

	localparam int PHASE_W   = PHASE_BITS + 1;
	localparam int TD_BITS   = $clog2(TABLE_DEPTH);
	localparam int STEP_BITS = TD_BITS + 2;
	localparam int ADDR_W    = TD_BITS + 1;

	localparam int INDEX_W = 13;
	localparam int COUNT_W = 13;
	localparam int ASTEP_W = 17;
	localparam int CFG_W   = 17;
	localparam int COORD_W = 16;
	localparam int Z_W     = 15;
	localparam int SINE_W  = 15;
	localparam int PROD_W  = 2 * COORD_W;
	localparam int FRAC    = 14;

	localparam int ONE_Q14 = 16384;
	localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(64);
	localparam logic [ASTEP_W-1:0] ASTEP_RESET = ASTEP_W'(1024);
	localparam logic [PHASE_W-1:0] FULL_TURN   = {1'b1, {PHASE_BITS{1'b0}}};
	localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1 << (FRAC - 1));

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam int SERIES_TERMS = 8;
	localparam longint unsigned SERIES_DIV [SERIES_TERMS] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
	};

	typedef enum logic {
		REG_COLUMN_COUNT = 1'b0,
		REG_ANGLE_STEP   = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic side;
		logic err;
		logic last;
	} slot_ctl_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic              neg;
	} sine_ref_t;

	typedef logic [SINE_W-1:0] qsine_tab_t [TABLE_DEPTH+1];

	// quarter-wave sine, Q14, from a Taylor series in Q30
	function automatic qsine_tab_t build_qsine();
		qsine_tab_t        t;
		longint unsigned   x;
		longint unsigned   x2;
		longint unsigned   term;
		longint            sum;
		longint            q;
		for (int i = 0; i <= TABLE_DEPTH; i++) begin
			x    = (longint'(i) * HALF_PI_Q30) / TABLE_DEPTH;
			x2   = (x * x) >> 30;
			term = x;
			sum  = longint'(x);
			for (int n = 1; n <= SERIES_TERMS; n++) begin
				term = ((term * x2) >> 30) / SERIES_DIV[n-1];
				if (n % 2 == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			q = (sum + 32768) >>> 16;
			if (q > ONE_Q14) begin
				q = ONE_Q14;
			end
			t[i] = SINE_W'(q);
		end
		return t;
	endfunction

	// table address and sign for a phase of one turn; quarter advances to cosine
	function automatic sine_ref_t sine_ref(logic [PHASE_BITS-1:0] phase, logic quarter);
		logic [PHASE_BITS+STEP_BITS-1:0] wide;
		logic [STEP_BITS-1:0]            stepi;
		logic [1:0]                      quad;
		logic [TD_BITS-1:0]              r;
		sine_ref_t                       res;
		wide  = {{STEP_BITS{1'b0}}, phase} << STEP_BITS;
		stepi = STEP_BITS'(wide >> PHASE_BITS);
		quad  = stepi[STEP_BITS-1 -: 2] + {1'b0, quarter};
		r     = stepi[TD_BITS-1:0];
		res.addr = quad[0] ? (ADDR_W'(TABLE_DEPTH) - {1'b0, r}) : {1'b0, r};
		res.neg  = quad[1];
		return res;
	endfunction

endpackage

// File: src/msvg_rom.sv
// Quarter-wave sine ROM with two registered read ports.
// Depends on msvg_pkg for the table builder and widths.
module msvg_rom (
	input  logic                         clk,
	input  logic                         en,
	input  logic [msvg_pkg::ADDR_W-1:0]  addr_a,
	input  logic [msvg_pkg::ADDR_W-1:0]  addr_b,
	output logic [msvg_pkg::SINE_W-1:0]  rd_a_s2,
	output logic [msvg_pkg::SINE_W-1:0]  rd_b_s2
);
	import msvg_pkg::*;

	localparam qsine_tab_t QSINE = build_qsine();

	always_ff @(posedge clk) begin
		if (en) begin
			rd_a_s2 <= QSINE[addr_a];
			rd_b_s2 <= QSINE[addr_b];
		end
	end

endmodule

// File: src/msvg_front.sv
// Configuration registers, input holding stage, vertex slot issue and phase multiply.
// Depends on msvg_pkg.
module msvg_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  msvg_pkg::cfg_reg_t            cfg_index,
	input  logic [msvg_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [msvg_pkg::INDEX_W-1:0]  column_index,
	input  logic                          en,
	output logic                          valid_s1,
	output msvg_pkg::slot_ctl_t           ctl_s1,
	output logic [msvg_pkg::PHASE_W-1:0]  phase_s1
);
	import msvg_pkg::*;

	logic [COUNT_W-1:0]         column_count_q;
	logic [ASTEP_W-1:0]         angle_step_q;
	logic                       hold_v_q;
	logic [INDEX_W-1:0]         hold_k_q;
	logic                       side_q;
	logic [COUNT_W-1:0]         cnt_eff;
	slot_ctl_t                  cur;
	logic                       issue;
	logic                       accept;
	logic [INDEX_W+ASTEP_W-1:0] prod;
	logic [PHASE_W-1:0]         phase_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= COUNT_RESET;
			angle_step_q   <= ASTEP_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_COLUMN_COUNT: column_count_q <= cfg_data[COUNT_W-1:0];
				REG_ANGLE_STEP:   angle_step_q   <= cfg_data[ASTEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (int'(column_count_q) > MAX_COLUMNS) begin
			cnt_eff = COUNT_W'(MAX_COLUMNS);
		end else begin
			cnt_eff = column_count_q;
		end
	end

	always_comb begin
		cur.side = side_q;
		cur.err  = hold_k_q > cnt_eff;
		cur.last = cur.err | side_q;
	end

	assign issue    = hold_v_q & en;
	assign in_ready = ~hold_v_q | (en & cur.last);
	assign accept   = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			side_q   <= 1'b0;
		end else if (accept) begin
			hold_v_q <= 1'b1;
			side_q   <= 1'b0;
		end else if (issue) begin
			if (cur.last) begin
				hold_v_q <= 1'b0;
			end else begin
				side_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hold_k_q <= column_index;
		end
	end

	assign prod = hold_k_q * angle_step_q;

	always_comb begin
		if (hold_k_q == cnt_eff) begin
			phase_next = FULL_TURN;
		end else begin
			phase_next = prod[PHASE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= hold_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1   <= cur;
			phase_s1 <= phase_next;
		end
	end

endmodule

// File: src/msvg_arith.sv
// Table lookup, radius forming, products and rounding: stages two to five.
// Depends on msvg_pkg and msvg_rom.
module msvg_arith (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                valid_s1,
	input  msvg_pkg::slot_ctl_t                 ctl_s1,
	input  logic [msvg_pkg::PHASE_W-1:0]        phase_s1,
	output logic                                valid_s5,
	output msvg_pkg::slot_ctl_t                 ctl_s5,
	output logic signed [msvg_pkg::COORD_W-1:0] x_s5,
	output logic signed [msvg_pkg::COORD_W-1:0] y_s5,
	output logic signed [msvg_pkg::Z_W-1:0]     z_s5
);
	import msvg_pkg::*;

	sine_ref_t                  ref_cu;
	sine_ref_t                  ref_su;
	sine_ref_t                  ref_ch;
	sine_ref_t                  ref_sh;
	logic [SINE_W-1:0]          mcu_s2;
	logic [SINE_W-1:0]          msu_s2;
	logic [SINE_W-1:0]          mch_s2;
	logic [SINE_W-1:0]          msh_s2;
	logic                       valid_s2;
	slot_ctl_t                  ctl_s2;
	logic [3:0]                 neg_s2;
	logic                       valid_s3;
	slot_ctl_t                  ctl_s3;
	logic signed [COORD_W-1:0]  radius_s3;
	logic signed [COORD_W-1:0]  cu_s3;
	logic signed [COORD_W-1:0]  su_s3;
	logic signed [Z_W-1:0]      z_s3;
	logic                       valid_s4;
	slot_ctl_t                  ctl_s4;
	logic signed [PROD_W-1:0]   px_s4;
	logic signed [PROD_W-1:0]   py_s4;
	logic signed [Z_W-1:0]      z_s4;
	logic signed [COORD_W-1:0]  mag_ch;
	logic signed [COORD_W-1:0]  mag_cu;
	logic signed [COORD_W-1:0]  mag_su;
	logic signed [Z_W-1:0]      mag_sh;
	logic                       neg_r;
	logic                       neg_z;
	logic signed [COORD_W-1:0]  radius_n;
	logic signed [COORD_W-1:0]  cu_n;
	logic signed [COORD_W-1:0]  su_n;
	logic signed [Z_W-1:0]      z_n;
	logic signed [PROD_W-1:0]   xb;
	logic signed [PROD_W-1:0]   yb;

	assign ref_cu = sine_ref(phase_s1[PHASE_BITS-1:0], 1'b1);
	assign ref_su = sine_ref(phase_s1[PHASE_BITS-1:0], 1'b0);
	assign ref_ch = sine_ref(phase_s1[PHASE_BITS:1], 1'b1);
	assign ref_sh = sine_ref(phase_s1[PHASE_BITS:1], 1'b0);

	msvg_rom u_rom_full (
		.clk     (clk),
		.en      (en),
		.addr_a  (ref_cu.addr),
		.addr_b  (ref_su.addr),
		.rd_a_s2 (mcu_s2),
		.rd_b_s2 (msu_s2)
	);

	msvg_rom u_rom_half (
		.clk     (clk),
		.en      (en),
		.addr_a  (ref_ch.addr),
		.addr_b  (ref_sh.addr),
		.rd_a_s2 (mch_s2),
		.rd_b_s2 (msh_s2)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s2 <= ctl_s1;
			neg_s2 <= {ref_cu.neg, ref_su.neg, ref_ch.neg, ref_sh.neg};
		end
	end

	// halve toward zero, then apply the side
	always_comb begin
		mag_ch   = $signed({2'b00, mch_s2[SINE_W-1:1]});
		mag_sh   = $signed({1'b0, msh_s2[SINE_W-1:1]});
		mag_cu   = $signed({1'b0, mcu_s2});
		mag_su   = $signed({1'b0, msu_s2});
		neg_r    = neg_s2[1] ^ ~ctl_s2.side;
		neg_z    = neg_s2[0] ^ ~ctl_s2.side;
		radius_n = neg_r ? (COORD_W'(ONE_Q14) - mag_ch) : (COORD_W'(ONE_Q14) + mag_ch);
		cu_n     = neg_s2[3] ? -mag_cu : mag_cu;
		su_n     = neg_s2[2] ? -mag_su : mag_su;
		z_n      = neg_z ? -mag_sh : mag_sh;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s3    <= ctl_s2;
			radius_s3 <= radius_n;
			cu_s3     <= cu_n;
			su_s3     <= su_n;
			z_s3      <= z_n;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s4 <= ctl_s3;
			px_s4  <= radius_s3 * cu_s3;
			py_s4  <= radius_s3 * su_s3;
			z_s4   <= z_s3;
		end
	end

	// round Q28 to Q14, ties upward
	assign xb = px_s4 + ROUND_BIAS;
	assign yb = py_s4 + ROUND_BIAS;

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s5 <= ctl_s4;
			x_s5   <= ctl_s4.err ? '0 : $signed(xb[FRAC +: COORD_W]);
			y_s5   <= ctl_s4.err ? '0 : $signed(yb[FRAC +: COORD_W]);
			z_s5   <= ctl_s4.err ? '0 : z_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

endmodule

// File: src/mobius_strip_vertex_generator.sv
// Mobius strip vertex generator. Each accepted column index yields two words, the
// v=-1 edge vertex then the v=+1 one, last set on the second; an index above the
// column count, capped at 4096, yields one word with range_error and last set and
// zero coordinates. Words go from the holding stage through stages one to five, and
// the next column is accepted as the last word of a column leaves the holding stage.
// The pipeline runs one vertex per cycle through a phase multiply, two dual-read
// sine ROMs, the radius stage, the multipliers and rounding, and stalls as a whole
// while a finished word waits to be taken. Depends on msvg_pkg, msvg_front,
// msvg_arith and the assertion macro header.
`include "mobius_strip_vertex_generator_defines.svh"

module mobius_strip_vertex_generator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  msvg_pkg::cfg_reg_t                  cfg_index,
	input  logic [msvg_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [msvg_pkg::INDEX_W-1:0]        column_index,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                side,
	output logic signed [msvg_pkg::COORD_W-1:0] x_coord,
	output logic signed [msvg_pkg::COORD_W-1:0] y_coord,
	output logic signed [msvg_pkg::Z_W-1:0]     z_coord,
	output logic                                range_error,
	output logic                                last
);
	import msvg_pkg::*;

	logic               en;
	logic               valid_s1;
	slot_ctl_t          ctl_s1;
	logic [PHASE_W-1:0] phase_s1;
	logic               valid_s5;
	slot_ctl_t          ctl_s5;

	// advance everything while the output word is empty or taken
	assign en = ~valid_s5 | out_ready;

	msvg_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.column_index (column_index),
		.en           (en),
		.valid_s1     (valid_s1),
		.ctl_s1       (ctl_s1),
		.phase_s1     (phase_s1)
	);

	msvg_arith u_arith (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s1 (valid_s1),
		.ctl_s1   (ctl_s1),
		.phase_s1 (phase_s1),
		.valid_s5 (valid_s5),
		.ctl_s5   (ctl_s5),
		.x_s5     (x_coord),
		.y_s5     (y_coord),
		.z_s5     (z_coord)
	);

	assign out_valid   = valid_s5;
	assign side        = ctl_s5.side;
	assign range_error = ctl_s5.err;
	assign last        = ctl_s5.last;

	`MSVG_ASSERT_NOW(a_err_word, out_valid && range_error, x_coord == '0 && y_coord == '0 && z_coord == '0 && last && !side, "range error word not zeroed")
	`MSVG_ASSERT_NEXT(a_pair_order, out_valid && out_ready && !range_error && !last, out_valid && side && !range_error, "second vertex does not follow first")
	`MSVG_ASSERT_NOW(a_last_side, out_valid && !range_error, last == side, "last flag out of step with side")

endmodule

// File: tb/sv/tb.sv
// Self-checking bench for mobius_strip_vertex_generator: a stimulus table, then random columns
// under many register settings, each word checked against the table or a local predictor.
// Needs only msvg_pkg and the generator RTL.
module tb;

	import msvg_pkg::*;

	localparam int QUARTER_WAVE_TOP = TABLE_DEPTH;
	localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
	localparam int RESET_COLUMNS = 64;
	localparam int RESET_STEP    = 1024;
	localparam int SETTLE_CYCLES = 10;
	localparam int DRAIN_CYCLES  = 20;
	localparam int LIMIT_CYCLES  = 400000;
	localparam int NUM_PHASES    = 13;
	localparam int PHASE_COLUMNS = 50;
	localparam int PICK_RANDOM   = -1;
	localparam int PICK_EVEN     = -2;

	typedef struct packed {
		logic                      side;
		logic signed [COORD_W-1:0] x_coord;
		logic signed [COORD_W-1:0] y_coord;
		logic signed [Z_W-1:0]     z_coord;
		logic                      range_error;
		logic                      last;
	} vertex_t;

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_TYPED,
		ROW_PREDICT
	} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [INDEX_W-1:0]   column;
		logic [COUNT_W-1:0]   columns;
		logic [ASTEP_W-1:0]   step;
		vertex_t              first;
		vertex_t              second;
	} dir_row_t;

	localparam vertex_t NO_WORD  = '0;
	localparam vertex_t FLAT_IN  = '{1'b0, 16'sd8192, 16'sd0, 15'sd0, 1'b0, 1'b0};
	localparam vertex_t FLAT_OUT = '{1'b1, 16'sd24576, 16'sd0, 15'sd0, 1'b0, 1'b1};
	localparam vertex_t TURN_IN  = '{1'b0, 16'sd24576, 16'sd0, 15'sd0, 1'b0, 1'b0};
	localparam vertex_t TURN_OUT = '{1'b1, 16'sd8192, 16'sd0, 15'sd0, 1'b0, 1'b1};
	localparam vertex_t OVER_IDX = '{1'b0, 16'sd0, 16'sd0, 15'sd0, 1'b1, 1'b1};

	localparam int NUM_ROWS = 24;
	localparam dir_row_t DIR_ROWS [NUM_ROWS] = '{
		'{ROW_TYPED,   13'd0,    13'd0,    17'd0,      FLAT_IN,  FLAT_OUT},
		'{ROW_TYPED,   13'd64,   13'd0,    17'd0,      TURN_IN,  TURN_OUT},
		'{ROW_TYPED,   13'd65,   13'd0,    17'd0,      OVER_IDX, NO_WORD},
		'{ROW_TYPED,   13'd8191, 13'd0,    17'd0,      OVER_IDX, NO_WORD},
		'{ROW_PREDICT, 13'd1,    13'd0,    17'd0,      NO_WORD,  NO_WORD},
		'{ROW_PREDICT, 13'd16,   13'd0,    17'd0,      NO_WORD,  NO_WORD},
		'{ROW_PREDICT, 13'd32,   13'd0,    17'd0,      NO_WORD,  NO_WORD},
		'{ROW_PREDICT, 13'd48,   13'd0,    17'd0,      NO_WORD,  NO_WORD},
		'{ROW_PREDICT, 13'd63,   13'd0,    17'd0,      NO_WORD,  NO_WORD},
		'{ROW_CFG,     13'd0,    13'd8191, 17'd16,     NO_WORD,  NO_WORD},
		'{ROW_TYPED,   13'd4096, 13'd0,    17'd0,      TURN_IN,  TURN_OUT},
		'{ROW_TYPED,   13'd4097, 13'd0,    17'd0,      OVER_IDX, NO_WORD},
		'{ROW_PREDICT, 13'd4095, 13'd0,    17'd0,      NO_WORD,  NO_WORD},
		'{ROW_CFG,     13'd0,    13'd0,    17'd1024,   NO_WORD,  NO_WORD},
		'{ROW_TYPED,   13'd0,    13'd0,    17'd0,      TURN_IN,  TURN_OUT},
		'{ROW_TYPED,   13'd1,    13'd0,    17'd0,      OVER_IDX, NO_WORD},
		'{ROW_CFG,     13'd0,    13'd3,    17'd131071, NO_WORD,  NO_WORD},
		'{ROW_PREDICT, 13'd1,    13'd0,    17'd0,      NO_WORD,  NO_WORD},
		'{ROW_PREDICT, 13'd2,    13'd0,    17'd0,      NO_WORD,  NO_WORD},
		'{ROW_TYPED,   13'd3,    13'd0,    17'd0,      TURN_IN,  TURN_OUT},
		'{ROW_CFG,     13'd0,    13'd4096, 17'd0,      NO_WORD,  NO_WORD},
		'{ROW_TYPED,   13'd4095, 13'd0,    17'd0,      FLAT_IN,  FLAT_OUT},
		'{ROW_TYPED,   13'd4096, 13'd0,    17'd0,      TURN_IN,  TURN_OUT},
		'{ROW_PREDICT, 13'd2048, 13'd0,    17'd0,      NO_WORD,  NO_WORD}
	};

	localparam int PHASE_COUNT [NUM_PHASES] = '{
		64, 1, 2, 4096, 8191, 5000, 0, 100, PICK_RANDOM, PICK_RANDOM, 4096, 3, PICK_RANDOM
	};
	localparam int PHASE_STEP [NUM_PHASES] = '{
		1024, 65536, 32768, 16, 16, 131071, 1024, 655, PICK_EVEN, PICK_RANDOM, 0, 21845,
		PICK_RANDOM
	};

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_write = 1'b0;
	cfg_reg_t                  cfg_index = REG_COLUMN_COUNT;
	logic [CFG_W-1:0]          cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [INDEX_W-1:0]        column_index = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic                      side;
	logic signed [COORD_W-1:0] x_coord;
	logic signed [COORD_W-1:0] y_coord;
	logic signed [Z_W-1:0]     z_coord;
	logic                      range_error;
	logic                      last;

	int          quarter_wave [0:QUARTER_WAVE_TOP];
	vertex_t     pending_vertices [$];
	int unsigned cur_columns = RESET_COLUMNS;
	int unsigned cur_step = RESET_STEP;
	bit          calm = 1'b0;
	int          fail_count = 0;
	int          columns_sent = 0;
	int          words_checked = 0;
	int          settings_used = 1;
	int          cycle_count = 0;

	mobius_strip_vertex_generator DUT (
		.clk, .arst_n, .cfg_write, .cfg_index, .cfg_data,
		.in_valid, .in_ready, .column_index,
		.out_valid, .out_ready, .side, .x_coord, .y_coord, .z_coord, .range_error, .last
	);

	always #2 clk = ~clk;

	function automatic void build_quarter_wave();
		longint unsigned idx;
		longint unsigned ang;
		longint unsigned ang_sq;
		longint unsigned term;
		longint unsigned n;
		longint          acc;
		longint          rnd;
		for (idx = 0; idx <= QUARTER_WAVE_TOP; idx++) begin
			ang    = (idx * QUARTER_TURN_Q30) / QUARTER_WAVE_TOP;
			ang_sq = (ang * ang) >> 30;
			term   = ang;
			acc    = longint'(ang);
			for (n = 1; n <= 8; n++) begin
				term = ((term * ang_sq) >> 30) / ((2 * n) * (2 * n + 1));
				if (n[0]) begin
					acc = acc - longint'(term);
				end else begin
					acc = acc + longint'(term);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			rnd = (acc + 32768) >>> 16;
			if (rnd > 16384) begin
				rnd = 16384;
			end
			quarter_wave[idx] = int'(rnd);
		end
	endfunction

	function automatic int wave_at(logic [PHASE_BITS-1:0] phase, bit cosine);
		longint pos;
		int     quad;
		int     r;
		int     mag;
		pos  = (longint'(phase) * 4 * TABLE_DEPTH) >>> PHASE_BITS;
		pos  = (pos + (cosine ? TABLE_DEPTH : 0)) % (4 * TABLE_DEPTH);
		quad = int'(pos / TABLE_DEPTH);
		r    = int'(pos % TABLE_DEPTH);
		mag  = (quad % 2 == 1) ? quarter_wave[TABLE_DEPTH - r] : quarter_wave[r];
		return (quad >= 2) ? -mag : mag;
	endfunction

	function automatic void queue_word(vertex_t w);
		pending_vertices = {pending_vertices, w};
	endfunction

	function automatic void column_vertices(logic [INDEX_W-1:0] col);
		int unsigned         k;
		int unsigned         lim;
		logic [PHASE_W-1:0]  ph2;
		int                  cu;
		int                  su;
		int                  ch2;
		int                  sh2;
		int                  rad;
		vertex_t             w;
		k   = col;
		lim = (cur_columns > MAX_COLUMNS) ? MAX_COLUMNS : cur_columns;
		if (k > lim) begin
			queue_word(OVER_IDX);
			return;
		end
		if (k == lim) begin
			ph2 = PHASE_W'(1) << PHASE_BITS;
		end else begin
			ph2 = PHASE_W'(longint'(k) * longint'(cur_step));
		end
		cu  = wave_at(ph2[PHASE_BITS-1:0], 1'b1);
		su  = wave_at(ph2[PHASE_BITS-1:0], 1'b0);
		ch2 = wave_at(ph2[PHASE_BITS:1], 1'b1) / 2;
		sh2 = wave_at(ph2[PHASE_BITS:1], 1'b0) / 2;
		for (int s = 0; s < 2; s++) begin
			rad           = (s == 1) ? 16384 + ch2 : 16384 - ch2;
			w.side        = s[0];
			w.x_coord     = COORD_W'((longint'(rad) * longint'(cu) + 8192) >>> 14);
			w.y_coord     = COORD_W'((longint'(rad) * longint'(su) + 8192) >>> 14);
			w.z_coord     = Z_W'((s == 1) ? sh2 : -sh2);
			w.range_error = 1'b0;
			w.last        = s[0];
			queue_word(w);
		end
	endfunction

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [INDEX_W-1:0] pick_column();
		int unsigned lim;
		lim = (cur_columns > MAX_COLUMNS) ? MAX_COLUMNS : cur_columns;
		case ($urandom_range(0, 19))
			0: return INDEX_W'($urandom_range(0, 8191));
			1: return INDEX_W'($urandom_range(lim + 1, 8191));
			2: return INDEX_W'(lim);
			3: return '0;
			default: return INDEX_W'($urandom_range(0, lim));
		endcase
	endfunction

	function automatic void check_word(vertex_t want, vertex_t got);
		if (got.side !== want.side) begin
			$error("side: expected %0d, got %0d", want.side, got.side);
			fail_count++;
		end
		if (got.x_coord !== want.x_coord) begin
			$error("x_coord: expected %0d, got %0d", want.x_coord, got.x_coord);
			fail_count++;
		end
		if (got.y_coord !== want.y_coord) begin
			$error("y_coord: expected %0d, got %0d", want.y_coord, got.y_coord);
			fail_count++;
		end
		if (got.z_coord !== want.z_coord) begin
			$error("z_coord: expected %0d, got %0d", want.z_coord, got.z_coord);
			fail_count++;
		end
		if (got.range_error !== want.range_error) begin
			$error("range_error: expected %0d, got %0d", want.range_error, got.range_error);
			fail_count++;
		end
		if (got.last !== want.last) begin
			$error("last: expected %0d, got %0d", want.last, got.last);
			fail_count++;
		end
	endfunction

	// hold valid across back-to-back words; drop it only ahead of a gap
	task automatic send_column(input logic [INDEX_W-1:0] col);
		int gap;
		gap = calm ? 0 : idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		column_index <= col;
		do @(posedge clk); while (!in_ready);
		columns_sent++;
	endtask

	task automatic program_regs(input logic [COUNT_W-1:0] cnt, input logic [ASTEP_W-1:0] stp);
		in_valid <= 1'b0;
		while (pending_vertices.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= REG_COLUMN_COUNT;
		cfg_data  <= CFG_W'(cnt);
		@(posedge clk);
		cfg_index <= REG_ANGLE_STEP;
		cfg_data  <= CFG_W'(stp);
		@(posedge clk);
		cfg_write   <= 1'b0;
		cur_columns = cnt;
		cur_step    = stp;
		settings_used++;
	endtask

	initial begin
		int unsigned cnt;
		int unsigned stp;
		build_quarter_wave();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_ROWS[i]) begin
			case (DIR_ROWS[i].kind)
				ROW_CFG: begin
					program_regs(DIR_ROWS[i].columns, DIR_ROWS[i].step);
				end
				ROW_TYPED: begin
					send_column(DIR_ROWS[i].column);
					queue_word(DIR_ROWS[i].first);
					if (!DIR_ROWS[i].first.range_error) begin
						queue_word(DIR_ROWS[i].second);
					end
				end
				default: begin
					send_column(DIR_ROWS[i].column);
					column_vertices(DIR_ROWS[i].column);
				end
			endcase
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			cnt = (PHASE_COUNT[p] == PICK_RANDOM) ? $urandom_range(1, MAX_COLUMNS) :
				PHASE_COUNT[p];
			if (PHASE_STEP[p] == PICK_RANDOM) begin
				stp = $urandom_range(0, 131071);
			end else if (PHASE_STEP[p] == PICK_EVEN) begin
				stp = 65536 / cnt;
			end else begin
				stp = PHASE_STEP[p];
			end
			program_regs(COUNT_W'(cnt), ASTEP_W'(stp));
			calm = ($urandom_range(0, 3) == 0);
			for (int j = 0; j < PHASE_COLUMNS; j++) begin
				logic [INDEX_W-1:0] col;
				col = pick_column();
				send_column(col);
				column_vertices(col);
			end
		end

		in_valid <= 1'b0;
		while (pending_vertices.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d columns under %0d register settings, %0d vertex words compared.",
			columns_sent, settings_used, words_checked);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		int stall;
		wait (arst_n);
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 200 : 20)) @(posedge clk);
			stall = idle_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : word_check
		vertex_t got;
		if (arst_n && out_valid && out_ready) begin
			got = '{side, x_coord, y_coord, z_coord, range_error, last};
			if (pending_vertices.size() == 0) begin
				$error("vertex word with nothing outstanding: side %0d x %0d y %0d z %0d",
					side, x_coord, y_coord, z_coord);
				fail_count++;
			end else begin
				check_word(pending_vertices.pop_front(), got);
				words_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == LIMIT_CYCLES) begin
			$error("timeout with %0d vertex words outstanding", pending_vertices.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

endmodule
